// ----- hdl/cl2n_pkg.sv -----
// shared types and constants for the column l2 norm block
// no dependencies; imported by column_l2_norm
`timescale 1ns / 1ps
`default_nettype none

package cl2n_pkg;

    // port widths fixed by the interface
    localparam int CHAN_PORT_W = 16;
    localparam int NORM_W      = 22;
    localparam int INDEX_W     = 10;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;
    // wide enough for any clamped row or column count
    localparam int COUNT_W     = 17;

    localparam int DEF_ROW_LIMIT    = 1024;
    localparam int DEF_MAX_COLUMNS  = 1024;
    localparam int DEF_CHANNEL_BITS = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROW_COUNT    = 2'd0,
        REG_COLUMN_COUNT = 2'd1,
        REG_CHANNEL_MODE = 2'd2,
        REG_UNUSED       = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACC,
        ST_ROOT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- hdl/column_l2_norm.sv -----
// column l2 norm: one shared multiplier squares the channels of each word,
// an iterative digit-by-digit unit takes the square root at each column end
// depends on cl2n_pkg
`timescale 1ns / 1ps
`default_nettype none

// Usage
// Input words (red, green, blue) arrive on in_valid / in_ready in column-major
// order. in_ready is high only while the sequencer is idle. An rgb word goes
// through the shared multiplier once per channel, then a final add; a scalar
// word (channel_mode = 1) takes only the red pass and the add.
// On the last row of a column the floor square root of the column sum is
// worked out one result bit per cycle, then loaded into the output register
// once that register is free.
// Results (norm, column_index) sit in an output register on out_valid /
// out_ready. A new word is taken while a result waits; only when the next
// root is ready and the receiver still stalls does the block hold off.
// Configuration writes (cfg_index, cfg_data) are always ready; index 3 is
// ignored. Writes are to be made while the block is idle; it does not enforce this.
// Reset clears the sum, positions and output valid, and sets row_count = 1,
// column_count = 1, channel_mode = 0.
module column_l2_norm
    import cl2n_pkg::*;
#(
    parameter int ROW_LIMIT    = DEF_ROW_LIMIT,
    parameter int MAX_COLUMNS  = DEF_MAX_COLUMNS,
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [CHAN_PORT_W-1:0] red,
    input  wire logic [CHAN_PORT_W-1:0] green,
    input  wire logic [CHAN_PORT_W-1:0] blue,

    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [NORM_W-1:0]           norm,
    output logic [INDEX_W-1:0]          column_index,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int PROD_W     = 2 * CHANNEL_BITS;
    localparam int SUM_W      = PROD_W + 2 + $clog2(ROW_LIMIT);
    localparam int ROOT_STEPS = (SUM_W + 1) / 2;
    localparam int RAD_W      = 2 * ROOT_STEPS;
    localparam int REM_W      = ROOT_STEPS + 2;
    localparam int ITER_W     = $clog2(ROOT_STEPS + 1);

    state_t                  state_reg, state_next;

    logic [CFG_DATA_W-1:0]   row_count_reg, column_count_reg;
    logic                    channel_mode_reg;

    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [INDEX_W-1:0]      row_pos_reg, row_pos_next;
    logic [INDEX_W-1:0]      col_pos_reg, col_pos_next;
    logic                    sel_reg, sel_next;
    logic [ITER_W-1:0]       iter_reg, iter_next;
    logic                    out_valid_reg, out_valid_next;

    // payload registers
    logic [CHANNEL_BITS-1:0] green_reg, blue_reg;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [RAD_W-1:0]        rad_reg, rad_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [ROOT_STEPS-1:0]   root_reg, root_next;
    logic [INDEX_W-1:0]      tag_reg, tag_next;
    logic [NORM_W-1:0]       norm_reg, norm_next;
    logic [INDEX_W-1:0]      index_reg, index_next;

    logic                    in_take;
    logic [CHANNEL_BITS-1:0] mul_in;
    logic [SUM_W-1:0]        acc_sum;
    logic [COUNT_W-1:0]      eff_rows, eff_cols;
    logic [COUNT_W-1:0]      row_pos_inc, col_pos_inc;
    logic [REM_W-1:0]        rem_shift, trial;

    assign in_ready     = (state_reg == ST_IDLE);
    assign in_take      = in_valid && in_ready;
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign norm         = norm_reg;
    assign column_index = index_reg;

    // counts of zero act as one, above the maximum act as the maximum
    always_comb
    begin
        if (row_count_reg == '0)
            eff_rows = COUNT_W'(1);
        else if (COUNT_W'(row_count_reg) > COUNT_W'(ROW_LIMIT))
            eff_rows = COUNT_W'(ROW_LIMIT);
        else
            eff_rows = COUNT_W'(row_count_reg);

        if (column_count_reg == '0)
            eff_cols = COUNT_W'(1);
        else if (COUNT_W'(column_count_reg) > COUNT_W'(MAX_COLUMNS))
            eff_cols = COUNT_W'(MAX_COLUMNS);
        else
            eff_cols = COUNT_W'(column_count_reg);
    end

    assign row_pos_inc = COUNT_W'(row_pos_reg) + COUNT_W'(1);
    assign col_pos_inc = COUNT_W'(col_pos_reg) + COUNT_W'(1);

    // shared multiplier input: red straight from the port on acceptance
    always_comb
    begin
        if (state_reg == ST_IDLE)
            mul_in = CHANNEL_BITS'(red);
        else if (sel_reg)
            mul_in = blue_reg;
        else
            mul_in = green_reg;
    end

    assign acc_sum = sum_reg + SUM_W'(prod_reg);

    // one root digit per cycle
    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};

    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        row_pos_next   = row_pos_reg;
        col_pos_next   = col_pos_reg;
        sel_next       = sel_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg;
        prod_next      = prod_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        tag_next       = tag_reg;
        norm_next      = norm_reg;
        index_next     = index_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    prod_next = PROD_W'(mul_in) * PROD_W'(mul_in);
                    sel_next  = 1'b0;
                    state_next = channel_mode_reg ? ST_ACC : ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                sum_next  = acc_sum;
                prod_next = PROD_W'(mul_in) * PROD_W'(mul_in);
                if (sel_reg)
                    state_next = ST_ACC;
                else
                    sel_next = 1'b1;
            end
            ST_ACC:
            begin
                if (row_pos_inc < eff_rows)
                begin
                    sum_next     = acc_sum;
                    row_pos_next = row_pos_inc[INDEX_W-1:0];
                    state_next   = ST_IDLE;
                end
                else
                begin
                    // column end: hand the total to the root unit, clear it
                    rad_next     = RAD_W'(acc_sum);
                    rem_next     = '0;
                    root_next    = '0;
                    iter_next    = ITER_W'(ROOT_STEPS - 1);
                    sum_next     = '0;
                    row_pos_next = '0;
                    tag_next     = col_pos_reg;
                    if (col_pos_inc < eff_cols)
                        col_pos_next = col_pos_inc[INDEX_W-1:0];
                    else
                        col_pos_next = '0;
                    state_next   = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                rad_next = rad_reg << 2;
                if (rem_shift >= trial)
                begin
                    rem_next  = rem_shift - trial;
                    root_next = {root_reg[ROOT_STEPS-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_shift;
                    root_next = {root_reg[ROOT_STEPS-2:0], 1'b0};
                end
                if (iter_reg == '0)
                    state_next = ST_DONE;
                else
                    iter_next = iter_reg - ITER_W'(1);
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    norm_next      = NORM_W'(root_reg);
                    index_next     = tag_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            row_count_reg    <= CFG_DATA_W'(1);
            column_count_reg <= CFG_DATA_W'(1);
            channel_mode_reg <= 1'b0;
            sum_reg          <= '0;
            row_pos_reg      <= '0;
            col_pos_reg      <= '0;
            sel_reg          <= 1'b0;
            iter_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            row_pos_reg   <= row_pos_next;
            col_pos_reg   <= col_pos_next;
            sel_reg       <= sel_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ROW_COUNT:    row_count_reg    <= cfg_data;
                    REG_COLUMN_COUNT: column_count_reg <= cfg_data;
                    REG_CHANNEL_MODE: channel_mode_reg <= cfg_data[0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            green_reg <= CHANNEL_BITS'(green);
            blue_reg  <= CHANNEL_BITS'(blue);
        end
        prod_reg  <= prod_next;
        rad_reg   <= rad_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        tag_reg   <= tag_next;
        norm_reg  <= norm_next;
        index_reg <= index_next;
    end

endmodule

`default_nettype wire

// ----- sim/tb_column_l2_norm.sv -----
// testbench for column_l2_norm: directed table then random phases, results checked
// against an in-bench column norm predictor; depends on cl2n_pkg and column_l2_norm
`timescale 1ns / 1ps

module tb_column_l2_norm
    import cl2n_pkg::*;
;

    localparam int SETTLE       = 64;        // covers a word plus a full root pass
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_WORDS = 1200;
    localparam longint LIMIT_NS = 10_000_000;

    typedef struct packed {
        logic [NORM_W-1:0]  norm;
        logic [INDEX_W-1:0] col;
    } col_norm_t;

    typedef enum { ROW_WORD, ROW_WRITE } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        cfg_reg_t               reg_sel;
        logic [CFG_DATA_W-1:0]  data;
        logic [CHAN_PORT_W-1:0] r;
        logic [CHAN_PORT_W-1:0] g;
        logic [CHAN_PORT_W-1:0] b;
        bit                     typed;
        col_norm_t              want;
    } plan_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [CHAN_PORT_W-1:0] red      = '0;
    logic [CHAN_PORT_W-1:0] green    = '0;
    logic [CHAN_PORT_W-1:0] blue     = '0;

    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [NORM_W-1:0]      norm;
    logic [INDEX_W-1:0]     column_index;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_reg_t               cfg_index = REG_ROW_COUNT;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // predictor copy of the registers and running state
    logic [CFG_DATA_W-1:0]  cfg_rows   = 11'd1;
    logic [CFG_DATA_W-1:0]  cfg_cols   = 11'd1;
    logic                   cfg_scalar = 1'b0;
    logic [63:0]            col_sum    = '0;
    int unsigned            row_at     = 0;
    int unsigned            col_at     = 0;

    col_norm_t   pending_norms[$];
    plan_row_t   plan[$];

    int unsigned errors        = 0;
    int unsigned words_sent    = 0;
    int unsigned norms_checked = 0;
    int unsigned writes_done   = 0;
    int unsigned phases        = 0;

    bit          tx_eager  = 1'b0;
    bit          rx_eager  = 1'b0;
    bit          hold_req  = 1'b0;
    int unsigned rx_wait   = 0;

    column_l2_norm dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .norm         (norm),
        .column_index (column_index),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [CHAN_PORT_W-1:0] rand_chan();
        int unsigned roll;
        logic [31:0] raw;
        roll = $urandom_range(0, 9);
        raw  = $urandom();
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return '1;
        else if (roll == 2)
            return CHAN_PORT_W'(raw[3:0]);
        else
            return raw[CHAN_PORT_W-1:0];
    endfunction

    function automatic int unsigned clamp_count(input logic [CFG_DATA_W-1:0] value,
                                                input int unsigned limit);
        if (value == 0)
            return 1;
        else if (value > limit)
            return limit;
        else
            return 32'(value);
    endfunction

    function automatic logic [NORM_W-1:0] floor_root(input logic [63:0] value);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] probe;
        rem   = value;
        root  = '0;
        probe = 64'h1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root[NORM_W-1:0];
    endfunction

    // one element into the column sum; done is set when the column closes
    task automatic add_element(input logic [CHAN_PORT_W-1:0] r,
                               input logic [CHAN_PORT_W-1:0] g,
                               input logic [CHAN_PORT_W-1:0] b,
                               output bit done, output col_norm_t res);
        int unsigned rows;
        int unsigned cols;
        logic [63:0] wr;
        logic [63:0] wg;
        logic [63:0] wb;
        rows = clamp_count(cfg_rows, DEF_ROW_LIMIT);
        cols = clamp_count(cfg_cols, DEF_MAX_COLUMNS);
        wr = 64'(r);
        wg = 64'(g);
        wb = 64'(b);
        col_sum = col_sum + wr * wr;
        if (!cfg_scalar)
            col_sum = col_sum + wg * wg + wb * wb;
        done = 1'b0;
        res  = '0;
        if (row_at + 1 < rows)
            row_at = row_at + 1;
        else
        begin
            done     = 1'b1;
            res.norm = floor_root(col_sum);
            res.col  = col_at[INDEX_W-1:0];
            col_sum  = '0;
            row_at   = 0;
            col_at   = (col_at + 1 < cols) ? col_at + 1 : 0;
        end
    endtask

    // leaves in_valid high on return so a back-to-back word needs no toggle
    task automatic send_word(input logic [CHAN_PORT_W-1:0] r,
                             input logic [CHAN_PORT_W-1:0] g,
                             input logic [CHAN_PORT_W-1:0] b,
                             input bit typed, input col_norm_t want);
        int unsigned gap;
        bit          done;
        col_norm_t   res;
        gap = tx_eager ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        red      <= r;
        green    <= g;
        blue     <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        add_element(r, g, b, done, res);
        if (typed)
            pending_norms.push_back(want);
        else if (done)
            pending_norms.push_back(res);
        words_sent++;
    endtask

    task automatic settle_idle();
        in_valid <= 1'b0;
        while (pending_norms.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (sel)
            REG_ROW_COUNT:    cfg_rows = value;
            REG_COLUMN_COUNT: cfg_cols = value;
            REG_CHANNEL_MODE: cfg_scalar = value[0];
            default:          ;
        endcase
        writes_done++;
        @(posedge clk);
    endtask

    function automatic plan_row_t word_row(input logic [CHAN_PORT_W-1:0] r,
                                           input logic [CHAN_PORT_W-1:0] g,
                                           input logic [CHAN_PORT_W-1:0] b,
                                           input bit typed,
                                           input int unsigned want_norm,
                                           input int unsigned want_col);
        plan_row_t row;
        row.kind      = ROW_WORD;
        row.reg_sel   = REG_UNUSED;
        row.data      = '0;
        row.r         = r;
        row.g         = g;
        row.b         = b;
        row.typed     = typed;
        row.want.norm = NORM_W'(want_norm);
        row.want.col  = INDEX_W'(want_col);
        return row;
    endfunction

    function automatic plan_row_t write_row(input cfg_reg_t sel,
                                            input logic [CFG_DATA_W-1:0] value);
        plan_row_t row;
        row       = word_row('0, '0, '0, 1'b0, 0, 0);
        row.kind  = ROW_WRITE;
        row.reg_sel = sel;
        row.data  = value;
        return row;
    endfunction

    // receiver: random back-pressure, plus a long hold on request
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_req)
        begin
            hold_req  <= 1'b0;
            rx_wait    = LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (rx_wait != 0)
        begin
            rx_wait    = rx_wait - 1;
            out_ready <= 1'b0;
        end
        else if (rx_eager || $urandom_range(0, 99) < 70)
            out_ready <= 1'b1;
        else
        begin
            rx_wait    = pick_gap();
            out_ready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        col_norm_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_norms.size() == 0)
            begin
                $display("%0t: unexpected word, norm %0d column %0d",
                         $time, norm, column_index);
                errors++;
            end
            else
            begin
                want = pending_norms.pop_front();
                norms_checked++;
                if (norm !== want.norm)
                begin
                    $display("%0t: norm expected %0d got %0d", $time, want.norm, norm);
                    errors++;
                end
                if (column_index !== want.col)
                begin
                    $display("%0t: column_index expected %0d got %0d",
                             $time, want.col, column_index);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int unsigned random_done;
        int unsigned n_words;
        int unsigned roll;
        logic [CFG_DATA_W-1:0] rows_val;
        logic [CFG_DATA_W-1:0] cols_val;
        logic [31:0]           raw;
        col_norm_t             none;

        none        = '0;
        random_done = 0;

        // reset state: one row, one column, rgb
        plan.push_back(word_row(16'h0000, 16'h0000, 16'h0000, 1'b1, 0, 0));
        plan.push_back(word_row(16'h0100, 16'h0000, 16'h0000, 1'b1, 256, 0));
        plan.push_back(word_row(16'h0000, 16'hFFFF, 16'h0000, 1'b1, 65535, 0));
        plan.push_back(word_row(16'h0000, 16'h0000, 16'hFFFF, 1'b1, 65535, 0));
        plan.push_back(word_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 0, 0));
        // out-of-range register index does nothing
        plan.push_back(write_row(REG_UNUSED, 11'h7FF));
        plan.push_back(word_row(16'h0300, 16'h0400, 16'h0000, 1'b1, 1280, 0));
        // scalar mode ignores green and blue
        plan.push_back(write_row(REG_CHANNEL_MODE, 11'd1));
        plan.push_back(word_row(16'hFFFF, 16'hAAAA, 16'h5555, 1'b1, 65535, 0));
        plan.push_back(write_row(REG_COLUMN_COUNT, 11'd3));
        plan.push_back(word_row(16'h0200, 16'hFFFF, 16'hFFFF, 1'b1, 512, 0));
        plan.push_back(word_row(16'h0001, 16'hFFFF, 16'hFFFF, 1'b1, 1, 1));
        plan.push_back(word_row(16'hFFFF, 16'h0000, 16'h0000, 1'b1, 65535, 2));
        plan.push_back(word_row(16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 0, 0));
        // zero counts act as one; the column left at 1 is still tagged, then wraps
        plan.push_back(write_row(REG_ROW_COUNT, 11'd0));
        plan.push_back(write_row(REG_COLUMN_COUNT, 11'd0));
        plan.push_back(word_row(16'h0005, 16'h1234, 16'h4321, 1'b1, 5, 1));
        plan.push_back(word_row(16'h0006, 16'h1234, 16'h4321, 1'b1, 6, 0));
        // oversized row count clamps to the maximum, then is lowered mid-column
        plan.push_back(write_row(REG_CHANNEL_MODE, 11'd0));
        plan.push_back(write_row(REG_ROW_COUNT, 11'h7FF));
        plan.push_back(write_row(REG_COLUMN_COUNT, 11'd1024));
        plan.push_back(word_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 0, 0));
        plan.push_back(word_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 0, 0));
        plan.push_back(word_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 0, 0));
        plan.push_back(write_row(REG_ROW_COUNT, 11'd2));
        plan.push_back(word_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 0, 0));
        // column position beyond a lowered column count still tags, then wraps
        plan.push_back(write_row(REG_ROW_COUNT, 11'd1));
        plan.push_back(word_row(16'h0100, 16'h0000, 16'h0000, 1'b1, 256, 1));
        plan.push_back(word_row(16'h0100, 16'h0000, 16'h0000, 1'b1, 256, 2));
        plan.push_back(word_row(16'h0100, 16'h0000, 16'h0000, 1'b1, 256, 3));
        plan.push_back(word_row(16'h0100, 16'h0000, 16'h0000, 1'b1, 256, 4));
        plan.push_back(write_row(REG_COLUMN_COUNT, 11'd2));
        plan.push_back(word_row(16'h0100, 16'h0000, 16'h0000, 1'b1, 256, 5));
        plan.push_back(word_row(16'h0100, 16'h0000, 16'h0000, 1'b1, 256, 0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                settle_idle();
                write_reg(plan[i].reg_sel, plan[i].data);
            end
            else
                send_word(plan[i].r, plan[i].g, plan[i].b, plan[i].typed, plan[i].want);
        end

        while (random_done < RANDOM_WORDS)
        begin
            settle_idle();
            phases++;

            roll = $urandom_range(0, 99);
            if (roll < 8)
                rows_val = 11'd0;
            else if (roll < 12)
                rows_val = $urandom_range(0, 1) ? 11'd1024 : 11'h7FF;
            else if (roll < 20)
                rows_val = CFG_DATA_W'($urandom_range(9, 40));
            else
                rows_val = CFG_DATA_W'($urandom_range(1, 8));

            roll = $urandom_range(0, 99);
            if (roll < 10)
                cols_val = 11'd0;
            else if (roll < 20)
                cols_val = CFG_DATA_W'($urandom_range(1024, 2047));
            else
                cols_val = CFG_DATA_W'($urandom_range(1, 12));

            // these phases fill the block against a stalled receiver
            if (phases == 2 || phases == 7)
                rows_val = 11'd1;

            write_reg(REG_ROW_COUNT, rows_val);
            write_reg(REG_COLUMN_COUNT, cols_val);
            write_reg(REG_CHANNEL_MODE, CFG_DATA_W'($urandom_range(0, 1)));
            if ($urandom_range(0, 4) == 0)
            begin
                raw = $urandom();
                write_reg(REG_UNUSED, raw[CFG_DATA_W-1:0]);
            end

            tx_eager = ($urandom_range(0, 4) == 0);
            rx_eager = ($urandom_range(0, 4) == 0);
            if (phases == 2 || phases == 7)
            begin
                tx_eager = 1'b1;
                rx_eager = 1'b0;
                hold_req <= 1'b1;
                n_words  = 40;
            end
            else if (rows_val >= 11'd1024)
                n_words = $urandom_range(3, 10);
            else
                n_words = $urandom_range(5, 60);

            repeat (n_words)
            begin
                send_word(rand_chan(), rand_chan(), rand_chan(), 1'b0, none);
                random_done++;
                // sender waits for every norm in flight now and then
                if ($urandom_range(0, 99) == 0)
                    settle_idle();
            end
        end

        settle_idle();
        $display("covered %0d words and %0d norms over %0d random phases, %0d register writes",
                 words_sent, norms_checked, phases, writes_done);
        $display("included clamped and zero counts, counts lowered mid-column, long output stalls");
        if (errors == 0 && pending_norms.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
